// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on a given clock, held off while the active-low reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check on the usual stream clock and reset
`define ASSERT_ACLK(label, prop, msg) `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== hw/rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// constants and register codes for the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qvr_pkg;

    // quaternion registers are signed q2.14
    localparam int QUAT_WIDTH = 16;
    localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

    // default coordinate width and fraction bits
    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 14;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = QUAT_WIDTH;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } cfg_reg_t;

endpackage

// ===== hw/rtl/quaternion_vector_rotation.sv =====
// four pipeline stages, each with its own valid bit
// throughput: one item per cycle while m_tready is high
// the rotation matrix is rebuilt from the quaternion registers every cycle and follows
// a write in the cycle after; an item's products go to prod_reg once the item leaves vec_reg
// reset (aresetn low, synchronous): quaternion goes to identity, all stages empty
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// rotates a stream of signed 3d vectors by a configured quaternion, with
// rounding to nearest (half up) and saturation of each rotated component
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_vector_rotation #(
    parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = qvr_pkg::FRAC_BITS_DEF,
    localparam int TDATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration writes
    input  logic                              cfg_we,
    input  logic [qvr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_data,

    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDATA_W-1:0]                s_tdata,   // in_x, in_y, in_z, zero pad

    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_W-1:0]                m_tdata,   // out_x, out_y, out_z, zero pad
    output logic [0:0]                        m_tuser    // clipped
);

    localparam int QW     = qvr_pkg::QUAT_WIDTH;
    localparam int C      = COORD_WIDTH;
    localparam int PW     = 2 * QW;
    localparam int ACC_W  = ((2 * QW > 2 * FRAC_BITS) ? 2 * QW : 2 * FRAC_BITS) + 3;
    localparam int MAT_W  = ACC_W - FRAC_BITS;
    localparam int PROD_W = MAT_W + C;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [C-1:0]     COORD_MAX = {1'b0, {(C - 1){1'b1}}};
    localparam logic signed [C-1:0]     COORD_MIN = {1'b1, {(C - 1){1'b0}}};

    // round an exact q(2f) entry half up to q(f)
    function automatic logic signed [MAT_W-1:0] round_entry(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a + ACC_HALF) >>> FRAC_BITS;
        return t[MAT_W-1:0];
    endfunction

    // quaternion registers
    logic signed [QW-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_w_reg <= qvr_pkg::QUAT_W_RESET;
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
        end else if (cfg_we) begin
            unique case (qvr_pkg::cfg_reg_t'(cfg_index))
                qvr_pkg::REG_QUAT_W: quat_w_reg <= cfg_data;
                qvr_pkg::REG_QUAT_X: quat_x_reg <= cfg_data;
                qvr_pkg::REG_QUAT_Y: quat_y_reg <= cfg_data;
                qvr_pkg::REG_QUAT_Z: quat_z_reg <= cfg_data;
            endcase
        end
    end

    // rotation matrix from the quaternion, one register stage
    logic signed [PW-1:0]    xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [ACC_W-1:0] acc [3][3];
    logic signed [MAT_W-1:0] mat_next [3][3];
    logic signed [MAT_W-1:0] mat_reg  [3][3];

    always_comb begin
        xx = PW'(quat_x_reg) * PW'(quat_x_reg);
        yy = PW'(quat_y_reg) * PW'(quat_y_reg);
        zz = PW'(quat_z_reg) * PW'(quat_z_reg);
        xy = PW'(quat_x_reg) * PW'(quat_y_reg);
        xz = PW'(quat_x_reg) * PW'(quat_z_reg);
        yz = PW'(quat_y_reg) * PW'(quat_z_reg);
        wx = PW'(quat_w_reg) * PW'(quat_x_reg);
        wy = PW'(quat_w_reg) * PW'(quat_y_reg);
        wz = PW'(quat_w_reg) * PW'(quat_z_reg);

        acc[0][0] = ACC_ONE - ((ACC_W'(yy) + ACC_W'(zz)) <<< 1);
        acc[0][1] = (ACC_W'(xy) - ACC_W'(wz)) <<< 1;
        acc[0][2] = (ACC_W'(xz) + ACC_W'(wy)) <<< 1;
        acc[1][0] = (ACC_W'(xy) + ACC_W'(wz)) <<< 1;
        acc[1][1] = ACC_ONE - ((ACC_W'(xx) + ACC_W'(zz)) <<< 1);
        acc[1][2] = (ACC_W'(yz) - ACC_W'(wx)) <<< 1;
        acc[2][0] = (ACC_W'(xz) - ACC_W'(wy)) <<< 1;
        acc[2][1] = (ACC_W'(yz) + ACC_W'(wx)) <<< 1;
        acc[2][2] = ACC_ONE - ((ACC_W'(xx) + ACC_W'(yy)) <<< 1);

        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mat_next[i][j] = round_entry(acc[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        mat_reg <= mat_next;
    end

    // stage enables: a stage moves when it is empty or the next one moves
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    assign en4      = !s4_valid_reg || m_tready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg <= s_tvalid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: unpack the input item
    logic signed [C-1:0] vec_next [3];
    logic signed [C-1:0] vec_reg  [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            vec_next[j] = s_tdata[j*C +: C];
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) vec_reg <= vec_next;
    end

    // stage 2: nine exact products
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = PROD_W'(mat_reg[i][j]) * PROD_W'(vec_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) prod_reg <= prod_next;
    end

    // stage 3: row sums, rounded half up by the fraction bits
    logic signed [SUM_W-1:0] sum [3];
    logic signed [SUM_W-1:0] sum_sh [3];
    logic signed [RND_W-1:0] rnd_next [3];
    logic signed [RND_W-1:0] rnd_reg  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                   + SUM_W'(prod_reg[i][2]) + SUM_HALF;
            sum_sh[i]   = sum[i] >>> FRAC_BITS;
            rnd_next[i] = sum_sh[i][RND_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) rnd_reg <= rnd_next;
    end

    // stage 4: saturate to the coordinate range, output register
    logic signed [C-1:0] out_next [3];
    logic signed [C-1:0] out_reg  [3];
    logic [2:0]          ovf;
    logic                clip_next, clip_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ovf[i] = !((&rnd_reg[i][RND_W-1:C-1]) || !(|rnd_reg[i][RND_W-1:C-1]));
            if (!ovf[i]) begin
                out_next[i] = rnd_reg[i][C-1:0];
            end else if (rnd_reg[i][RND_W-1]) begin
                out_next[i] = COORD_MIN;
            end else begin
                out_next[i] = COORD_MAX;
            end
        end
        clip_next = |ovf;
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            out_reg  <= out_next;
            clip_reg <= clip_next;
        end
    end

    // pack the result item
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            m_tdata[i*C +: C] = out_reg[i];
        end
    end

    assign m_tvalid   = s4_valid_reg;
    assign m_tuser[0] = clip_reg;

    // terms used by the checks below
    logic pipe_full;
    logic out_at_limit;

    assign pipe_full    = s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg;
    assign out_at_limit = (out_reg[0] == COORD_MAX) || (out_reg[0] == COORD_MIN)
                       || (out_reg[1] == COORD_MAX) || (out_reg[1] == COORD_MIN)
                       || (out_reg[2] == COORD_MAX) || (out_reg[2] == COORD_MIN);

    // input only stalls when every stage holds an item
    `ASSERT_ACLK(a_full_when_stalled, !s_tready |-> pipe_full, "input stalled, stage empty")

    // an item moving out of stage 2 shows up in stage 3
    `ASSERT_ACLK(a_stage3_filled, s2_valid_reg && en3 |=> s3_valid_reg, "item lost in stage 3")

    // a clipped result has a component at a range limit
    `ASSERT_ACLK(a_clip_at_limit, m_tvalid && clip_reg |-> out_at_limit, "clip with no limit")

endmodule

// ===== dv/quaternion_vector_rotation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_checker
// watches the config port and both item channels, predicts every rotated
// vector from its own copy of the quaternion and compares results in order
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [qvr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [71:0]                       s_tdata,   // in_x, in_y, in_z
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [71:0]                       m_tdata,   // out_x, out_y, out_z
    input  logic [0:0]                        m_tuser,   // clipped
    output int                                outstanding,
    output int                                fail_count
);

    localparam int CW   = qvr_pkg::COORD_WIDTH_DEF;
    localparam int FRAC = qvr_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rz;
        logic                 clip;
    } rotated_vec_t;

    // quaternion as the block should hold it
    logic signed [qvr_pkg::QUAT_WIDTH-1:0] q_w, q_x, q_y, q_z;
    rotated_vec_t rotations_due[$];

    // add half an lsb and shift with floor
    function automatic longint q_round(input longint v);
        return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // rotation matrix from the quaternion, then matrix times vector
    function automatic rotated_vec_t rotate_vector(input logic signed [CW-1:0] vx,
                                                   input logic signed [CW-1:0] vy,
                                                   input logic signed [CW-1:0] vz);
        longint w, x, y, z, unity, acc, hi, lo;
        longint mat [3][3];
        longint vec [3];
        longint res [3];
        rotated_vec_t r;
        w = q_w;
        x = q_x;
        y = q_y;
        z = q_z;
        unity = longint'(1) <<< (2 * FRAC);
        mat[0][0] = q_round(unity - 2 * (y * y + z * z));
        mat[0][1] = q_round(2 * (x * y - w * z));
        mat[0][2] = q_round(2 * (x * z + w * y));
        mat[1][0] = q_round(2 * (x * y + w * z));
        mat[1][1] = q_round(unity - 2 * (x * x + z * z));
        mat[1][2] = q_round(2 * (y * z - w * x));
        mat[2][0] = q_round(2 * (x * z - w * y));
        mat[2][1] = q_round(2 * (y * z + w * x));
        mat[2][2] = q_round(unity - 2 * (x * x + y * y));
        vec[0] = vx;
        vec[1] = vy;
        vec[2] = vz;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        r.clip = 1'b0;
        // sums stay well inside 64 bits, so the product is exact
        for (int i = 0; i < 3; i++) begin
            acc = q_round(mat[i][0] * vec[0] + mat[i][1] * vec[1] + mat[i][2] * vec[2]);
            if (acc > hi) begin
                acc = hi;
                r.clip = 1'b1;
            end else if (acc < lo) begin
                acc = lo;
                r.clip = 1'b1;
            end
            res[i] = acc;
        end
        r.rx = res[0][CW-1:0];
        r.ry = res[1][CW-1:0];
        r.rz = res[2][CW-1:0];
        return r;
    endfunction

    initial begin
        fail_count = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        rotated_vec_t want;
        logic signed [CW-1:0] got_x, got_y, got_z;
        if (!aresetn) begin
            rotations_due.delete();
            q_w = qvr_pkg::QUAT_W_RESET;
            q_x = '0;
            q_y = '0;
            q_z = '0;
        end else begin
            // result side: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_x = m_tdata[CW-1:0];
                got_y = m_tdata[2*CW-1:CW];
                got_z = m_tdata[3*CW-1:2*CW];
                if (rotations_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result item with none pending: x=%0d y=%0d z=%0d clip=%0b",
                                 $realtime, got_x, got_y, got_z, m_tuser[0]);
                end else begin
                    want = rotations_due.pop_front();
                    if (got_x !== want.rx || got_y !== want.ry || got_z !== want.rz ||
                        m_tuser[0] !== want.clip) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: want x=%0d y=%0d z=%0d clip=%0b",
                                     $realtime, want.rx, want.ry, want.rz, want.clip);
                            $display("    got x=%0d y=%0d z=%0d clip=%0b",
                                     got_x, got_y, got_z, m_tuser[0]);
                        end
                    end
                end
            end
            // input side: predict with the quaternion in force now
            if (s_tvalid && s_tready)
                rotations_due.push_back(rotate_vector(s_tdata[CW-1:0],
                                                      s_tdata[2*CW-1:CW],
                                                      s_tdata[3*CW-1:2*CW]));
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    qvr_pkg::REG_QUAT_W: q_w = cfg_data;
                    qvr_pkg::REG_QUAT_X: q_x = cfg_data;
                    qvr_pkg::REG_QUAT_Y: q_y = cfg_data;
                    qvr_pkg::REG_QUAT_Z: q_z = cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding <= rotations_due.size();
    end

endmodule

// ===== dv/quaternion_vector_rotation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_tb
// drives vectors through the rotation block under a series of quaternions
// (identity, extremes, rounding cases, random), with random stalls on both
// channels; the checker predicts and compares every rotated vector
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_tb;

    localparam int CW      = qvr_pkg::COORD_WIDTH_DEF;
    localparam int TDATA_W = ((3 * CW + 7) / 8) * 8;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 100;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_we;
    logic [qvr_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [TDATA_W-1:0]                s_tdata;   // in_x, in_y, in_z, zero pad
    logic                              m_tvalid;
    logic                              m_tready;
    logic [TDATA_W-1:0]                m_tdata;   // out_x, out_y, out_z, zero pad
    logic [0:0]                        m_tuser;   // clipped
    int                                outstanding;
    int                                fail_count;
    bit                                idle_on;

    always #1 aclk = ~aclk;

    quaternion_vector_rotation DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    quaternion_vector_rotation_checker rotation_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // one vector, with an optional idle burst before it
    task automatic push_vector(input logic signed [CW-1:0] vx,
                               input logic signed [CW-1:0] vy,
                               input logic signed [CW-1:0] vz);
        logic [TDATA_W-1:0] word;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        word = '0;
        word[3*CW-1:0] = {vz, vy, vx};
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait until every result is out
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
    endtask

    // new quaternion, written only once the block is empty
    task automatic load_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        qvr_pkg::cfg_reg_t sel  [4];
        logic [15:0]       vals [4];
        sel  = '{qvr_pkg::REG_QUAT_W, qvr_pkg::REG_QUAT_X,
                 qvr_pkg::REG_QUAT_Y, qvr_pkg::REG_QUAT_Z};
        vals = '{w, x, y, z};
        drain_pipeline();
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= sel[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // corner vectors: zero, both extremes, mixed extremes, a rounding probe
    task automatic push_corners();
        push_vector('0, '0, '0);
        push_vector(C_MAX, C_MAX, C_MAX);
        push_vector(C_MIN, C_MIN, C_MIN);
        push_vector(C_MAX, C_MIN, '0);
        push_vector(CW'(1), '0, CW'(-1));
    endtask

    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1: return CW'($urandom);
            2:    return CW'($urandom_range(0, 8) - 4);
            3:    return CW'($urandom_range(0, 131072) - 65536);
            4:    return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default: return $urandom_range(0, 1) ? CW'(1) : CW'(-1);
        endcase
    endfunction

    function automatic logic [15:0] pick_quat_part();
        case ($urandom_range(0, 4))
            0:    return 16'($urandom);
            1, 2: return 16'($urandom_range(0, 32768) - 16384);
            3:    return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'd0;
                    1: return 16'd4096;
                    2: return 16'd8192;
                    default: return 16'd16384;
                endcase
            end
        endcase
    endfunction

    // result side back-pressure
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        idle_on = 1'b1;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= qvr_pkg::REG_QUAT_W;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity from reset
        push_corners();
        // most negative value everywhere: heavy scaling, saturation
        load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_corners();
        // most positive value everywhere
        load_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        push_corners();
        // small turn about z: off-diagonal entries of one half, ties in rounding
        load_quat(16'd16384, 16'd0, 16'd0, 16'd4096);
        push_corners();
        // quarter turn about x
        load_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
        push_corners();

        // random quaternions, the last phase without stalls
        for (int ph = 0; ph < N_PHASES; ph++) begin
            load_quat(pick_quat_part(), pick_quat_part(), pick_quat_part(),
                      pick_quat_part());
            idle_on = (ph == N_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_vector(pick_coord(), pick_coord(), pick_coord());
        end

        drain_pipeline();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/qvr_pkg.sv
hw/rtl/quaternion_vector_rotation.sv
dv/quaternion_vector_rotation_checker.sv
dv/quaternion_vector_rotation_tb.sv
